[sv/asre_pkg.sv]
// ----------------------------------------------------------------------------
// asre_pkg
// Types, constants and small decode functions shared by the rate entry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asre_pkg;

    localparam int IDX_W       = 9;
    localparam int POP_W       = 7;
    localparam int RATE_W      = 57;
    localparam int Q_W         = 32;
    localparam int PROD_W      = 2 * Q_W;
    localparam int MUT_SHIFT   = 12;
    localparam int MVAL_W      = PROD_W - MUT_SHIFT + 2;
    localparam int QUO_W       = 48;
    localparam int DIV_STEPS   = 6;
    localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
    localparam int NUM_LANES   = 3;
    localparam int NUM_PAIRS   = 6;
    localparam int NUM_NT      = 4;
    localparam int BLK_W       = 3;

    localparam logic [IDX_W-1:0] FIXED_STATES = IDX_W'(NUM_NT);

    localparam int CFG_AW     = 6;
    localparam int CFG_DW     = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MUT_AC_AG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUT_AT_CG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MUT_CT_GT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_A_C  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_G_T  = 3'd5;

    localparam logic [POP_W-1:0]  POP_RESET  = 7'd10;
    localparam logic [CFG_DW-1:0] MUT_RESET  = 64'd184468845406150;
    localparam logic [CFG_DW-1:0] FREQ_RESET = 64'd1152921504875282432;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_ZERO   = 3'd0;
    localparam logic [KIND_W-1:0] K_DRIFT  = 3'd1;
    localparam logic [KIND_W-1:0] K_MUT    = 3'd2;
    localparam logic [KIND_W-1:0] K_NDRIFT = 3'd3;
    localparam logic [KIND_W-1:0] K_NMUT   = 3'd4;

    typedef struct packed {
        logic [POP_W-1:0]  pop_size;
        logic [NUM_PAIRS-1:0][Q_W-1:0] mu;
        logic [NUM_NT-1:0][Q_W-1:0]    fr;
    } cfg_t;

    typedef struct packed {
        logic             fixed;
        logic [1:0]       x;
        logic [1:0]       y;
        logic [POP_W-1:0] cnt;
    } state_t;

    function automatic logic [1:0] pair_first(input logic [BLK_W-1:0] blk);
        logic [1:0] nt;
        case (blk)
            3'd0:    nt = 2'd0;
            3'd1:    nt = 2'd0;
            3'd2:    nt = 2'd0;
            3'd3:    nt = 2'd1;
            3'd4:    nt = 2'd1;
            default: nt = 2'd2;
        endcase
        return nt;
    endfunction

    function automatic logic [1:0] pair_second(input logic [BLK_W-1:0] blk);
        logic [1:0] nt;
        case (blk)
            3'd0:    nt = 2'd1;
            3'd1:    nt = 2'd2;
            3'd2:    nt = 2'd3;
            3'd3:    nt = 2'd2;
            3'd4:    nt = 2'd3;
            default: nt = 2'd3;
        endcase
        return nt;
    endfunction

    function automatic logic [2:0] pair_index(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] lo;
        logic [1:0] hi;
        logic [2:0] k;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case (lo)
            2'd0:    k = {1'b0, hi} - 3'd1;
            2'd1:    k = {1'b0, hi} + 3'd1;
            default: k = 3'd5;
        endcase
        return k;
    endfunction

endpackage

[sv/asre_query_if.sv]
// ----------------------------------------------------------------------------
// asre_query_if
// Valid/ready channel carrying one pair of state indices per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asre_query_if
    import asre_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] from_state;
    logic [IDX_W-1:0] to_state;

    modport source (output valid, output from_state, output to_state, input ready);
    modport sink (input valid, input from_state, input to_state, output ready);
endinterface

[sv/asre_result_if.sv]
// ----------------------------------------------------------------------------
// asre_result_if
// Valid/ready channel carrying one rate matrix entry per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asre_result_if
    import asre_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate;
    logic                     bad_state;

    modport source (output valid, output rate, output bad_state, input ready);
    modport sink (input valid, input rate, input bad_state, output ready);
endinterface

[sv/asre_cfg_regs.sv]
// ----------------------------------------------------------------------------
// asre_cfg_regs
// APB register file holding population size, mutation rates and frequencies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asre_cfg_regs
    import asre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [POP_W-1:0]     pop_size_reg;
    logic [CFG_DW-1:0]    mut_ac_ag_reg;
    logic [CFG_DW-1:0]    mut_at_cg_reg;
    logic [CFG_DW-1:0]    mut_ct_gt_reg;
    logic [CFG_DW-1:0]    freq_a_c_reg;
    logic [CFG_DW-1:0]    freq_g_t_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_AW-1:CFG_AW-CFG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_size_reg  <= POP_RESET;
            mut_ac_ag_reg <= MUT_RESET;
            mut_at_cg_reg <= MUT_RESET;
            mut_ct_gt_reg <= MUT_RESET;
            freq_a_c_reg  <= FREQ_RESET;
            freq_g_t_reg  <= FREQ_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_POP_SIZE:  pop_size_reg  <= pwdata[POP_W-1:0];
                REG_MUT_AC_AG: mut_ac_ag_reg <= pwdata;
                REG_MUT_AT_CG: mut_at_cg_reg <= pwdata;
                REG_MUT_CT_GT: mut_ct_gt_reg <= pwdata;
                REG_FREQ_A_C:  freq_a_c_reg  <= pwdata;
                REG_FREQ_G_T:  freq_g_t_reg  <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POP_SIZE:  prdata = CFG_DW'(pop_size_reg);
            REG_MUT_AC_AG: prdata = mut_ac_ag_reg;
            REG_MUT_AT_CG: prdata = mut_at_cg_reg;
            REG_MUT_CT_GT: prdata = mut_ct_gt_reg;
            REG_FREQ_A_C:  prdata = freq_a_c_reg;
            REG_FREQ_G_T:  prdata = freq_g_t_reg;
            default:       prdata = '0;
        endcase
    end

    assign cfg.pop_size = pop_size_reg;
    assign cfg.mu       = {mut_ct_gt_reg, mut_at_cg_reg, mut_ac_ag_reg};
    assign cfg.fr       = {freq_g_t_reg, freq_a_c_reg};

endmodule

[sv/asre_decode.sv]
// ----------------------------------------------------------------------------
// asre_decode
// Splits a state index into fixed nucleotide or pair block, offset and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asre_decode
    import asre_pkg::*;
(
    input  logic [IDX_W-1:0]                  s,
    input  logic [POP_W-1:0]                  n,
    input  logic [NUM_PAIRS-2:0][IDX_W-1:0]   thr,
    output state_t                            st
);

    always_comb
    begin
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] off;
        logic [BLK_W-1:0] blk;
        d    = s - FIXED_STATES;
        base = '0;
        blk  = '0;
        // The block boundaries rise monotonically, so the last one passed is the base.
        for (int k = 0; k < NUM_PAIRS - 1; k++)
        begin
            if (d >= thr[k])
            begin
                blk  = blk + BLK_W'(1);
                base = thr[k];
            end
        end
        off      = d - base;
        st.fixed = (s < FIXED_STATES);
        st.x     = st.fixed ? s[1:0] : pair_first(blk);
        st.y     = pair_second(blk);
        st.cnt   = st.fixed ? n : off[POP_W-1:0] + POP_W'(1);
    end

endmodule

[sv/asre_div_step.sv]
// ----------------------------------------------------------------------------
// asre_div_step
// A group of restoring division steps, producing several quotient bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asre_div_step
    import asre_pkg::*;
#(
    parameter int DEN_W = 13
)
(
    input  logic [DEN_W-1:0] rem_in,
    input  logic [QUO_W-1:0] quo_in,
    input  logic [DEN_W-1:0] den,
    output logic [DEN_W-1:0] rem_out,
    output logic [QUO_W-1:0] quo_out
);

    always_comb
    begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] q;
        logic             qb;
        r = rem_in;
        q = quo_in;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            t  = {r, 1'b0};
            qb = (t >= {1'b0, den});
            if (qb)
            begin
                t = t - {1'b0, den};
            end
            r = t[DEN_W-1:0];
            q = {q[QUO_W-2:0], qb};
        end
        rem_out = r;
        quo_out = q;
    end

endmodule

[sv/allele_state_rate_entry.sv]
// ----------------------------------------------------------------------------
// allele_state_rate_entry
// Streams one boundary-mutation rate matrix entry per index pair.
//
// The query channel takes a beat of (from_state, to_state); the result
// channel returns one beat of (rate, bad_state) per query, in order. The
// rate is signed Q8.48; bad_state flags an index at or beyond 4+6(N-1),
// in which case rate is zero. Configuration goes through the APB port,
// one register per 8-byte slot; the user must see that it is written only
// while the block is empty, which the block itself does not enforce.
// Throughput is one beat per cycle unless the result side stalls. The
// accepting edge loads the decode stage, which is followed in order by
// the classification stage, eight drift divider stages of six quotient
// bits each and the output register. The mutation products are formed
// alongside the first two divider stages. Reset empties the pipeline and
// loads the register defaults (N = 10, rates 1e-5, frequencies 1.0). When
// the result side stalls, the held beat stays and upstream stages keep
// filling their empty slots; query ready drops only once every stage
// holds a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module allele_state_rate_entry
    import asre_pkg::*;
#(
    parameter int MAX_POP = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    asre_query_if.sink        query,
    asre_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEN_W = $clog2(MAX_POP * MAX_POP + 1);
    localparam int LAST  = DIV_STAGES - 1;
    localparam logic [POP_W-1:0] MAX_N = POP_W'(MAX_POP);
    localparam logic [POP_W-1:0] MIN_N = POP_W'(2);

    cfg_t                               cfg;
    logic [POP_W-1:0]                   n_eff;
    logic [POP_W-1:0]                   nm1;
    logic [2*POP_W-1:0]                 n_sq;
    logic [DEN_W-1:0]                   den;
    logic [NUM_PAIRS-2:0][IDX_W-1:0]    thr;
    logic [IDX_W-1:0]                   limit;

    state_t                             st1;
    state_t                             st2;

    logic                               p1_rdy;
    logic                               p1_vld_reg;
    state_t                             p1_st1_reg;
    state_t                             p1_st2_reg;
    logic                               p1_same_reg;
    logic                               p1_bad_reg;

    logic                               p2_rdy;
    logic                               p2_vld_reg;
    logic [KIND_W-1:0]                  p2_kind_reg;
    logic                               p2_bad_reg;
    logic [DEN_W-1:0]                   p2_num_reg;
    logic [NUM_LANES-1:0]               p2_mask_reg;
    logic [NUM_LANES-1:0][Q_W-1:0]      p2_mu_reg;
    logic [NUM_LANES-1:0][Q_W-1:0]      p2_fr_reg;

    logic [KIND_W-1:0]                  kind_next;
    logic [DEN_W-1:0]                   num_next;
    logic [NUM_LANES-1:0]               mask_next;
    logic [NUM_LANES-1:0][Q_W-1:0]      mu_next;
    logic [NUM_LANES-1:0][Q_W-1:0]      fr_next;

    logic                               dv_rdy     [DIV_STAGES];
    logic                               dv_vld_reg [DIV_STAGES];
    logic [DEN_W-1:0]                   dv_rem_reg [DIV_STAGES];
    logic [QUO_W-1:0]                   dv_quo_reg [DIV_STAGES];
    logic [KIND_W-1:0]                  dv_kind_reg[DIV_STAGES];
    logic                               dv_bad_reg [DIV_STAGES];
    logic [DEN_W-1:0]                   dv_rem_next[DIV_STAGES];
    logic [QUO_W-1:0]                   dv_quo_next[DIV_STAGES];
    logic [NUM_LANES-1:0]               d0_mask_reg;
    logic [NUM_LANES-1:0][PROD_W-1:0]   d0_prod_reg;
    logic [MVAL_W-1:0]                  mval_reg   [1:LAST];

    logic                               out_rdy;
    logic                               out_vld_reg;
    logic [RATE_W-1:0]                  out_rate_reg;
    logic                               out_bad_reg;
    logic [RATE_W-1:0]                  rate_next;

    asre_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        if (cfg.pop_size < MIN_N)
        begin
            n_eff = MIN_N;
        end
        else if (cfg.pop_size > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = cfg.pop_size;
        end
        nm1  = n_eff - POP_W'(1);
        n_sq = (2*POP_W)'(n_eff) * (2*POP_W)'(n_eff);
        den  = n_sq[DEN_W-1:0];
        for (int k = 0; k < NUM_PAIRS - 1; k++)
        begin
            thr[k] = IDX_W'(nm1) * IDX_W'(k + 1);
        end
        limit = FIXED_STATES + IDX_W'(nm1) * IDX_W'(NUM_PAIRS);
    end

    // Stage 1: index decode.
    asre_decode u_decode_from (
        .s   (query.from_state),
        .n   (n_eff),
        .thr (thr),
        .st  (st1)
    );

    asre_decode u_decode_to (
        .s   (query.to_state),
        .n   (n_eff),
        .thr (thr),
        .st  (st2)
    );

    assign p1_rdy      = !p1_vld_reg || p2_rdy;
    assign query.ready = p1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (p1_rdy)
        begin
            p1_vld_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_rdy && query.valid)
        begin
            p1_st1_reg  <= st1;
            p1_st2_reg  <= st2;
            p1_same_reg <= (query.from_state == query.to_state);
            p1_bad_reg  <= (query.from_state >= limit) || (query.to_state >= limit);
        end
    end

    // Stage 2: entry classification, drift numerator and mutation operands.
    always_comb
    begin
        logic             same_b;
        logic [POP_W:0]   i1;
        logic [POP_W:0]   i2;
        logic [1:0]       tgt;
        logic [1:0]       lane;
        logic [1:0]       a;
        logic [1:0]       bj;
        logic [2*POP_W-1:0] prod;
        a      = p1_st1_reg.x;
        i1     = {1'b0, p1_st1_reg.cnt};
        i2     = {1'b0, p1_st2_reg.cnt};
        same_b = (p1_st1_reg.fixed && p1_st2_reg.fixed)
                 || (!p1_st1_reg.fixed && !p1_st2_reg.fixed
                     && (p1_st1_reg.y == p1_st2_reg.y));
        tgt       = p1_st2_reg.x;
        kind_next = K_ZERO;
        if (p1_same_reg)
        begin
            kind_next = p1_st1_reg.fixed ? K_NMUT : K_NDRIFT;
        end
        else if ((p1_st1_reg.x == p1_st2_reg.x)
                 && (same_b || p1_st1_reg.fixed || p1_st2_reg.fixed))
        begin
            if (i1 + (POP_W+1)'(1) == i2)
            begin
                kind_next = K_DRIFT;
            end
            else if (i1 == i2 + (POP_W+1)'(1))
            begin
                if (p1_st1_reg.fixed)
                begin
                    kind_next = K_MUT;
                    tgt       = p1_st2_reg.y;
                end
                else
                begin
                    kind_next = K_DRIFT;
                end
            end
        end
        else if (p1_st1_reg.fixed && !p1_st2_reg.fixed
                 && (p1_st1_reg.x == p1_st2_reg.y) && (p1_st2_reg.cnt == POP_W'(1)))
        begin
            kind_next = K_MUT;
            tgt       = p1_st2_reg.x;
        end
        else if (!p1_st1_reg.fixed && p1_st2_reg.fixed
                 && (p1_st1_reg.y == p1_st2_reg.x) && (p1_st1_reg.cnt == POP_W'(1)))
        begin
            kind_next = K_DRIFT;
        end

        // Lanes cover the three nucleotides other than the source, in ascending order.
        lane = (tgt < a) ? tgt : tgt - 2'd1;
        case (kind_next)
            K_MUT:   mask_next = NUM_LANES'(1) << lane;
            K_NMUT:  mask_next = {NUM_LANES{1'b1}};
            default: mask_next = '0;
        endcase

        for (int j = 0; j < NUM_LANES; j++)
        begin
            bj         = (2'(j) < a) ? 2'(j) : 2'(j) + 2'd1;
            mu_next[j] = cfg.mu[pair_index(a, bj)];
            fr_next[j] = cfg.fr[bj];
        end

        prod     = (2*POP_W)'(p1_st1_reg.cnt) * (2*POP_W)'(n_eff - p1_st1_reg.cnt);
        num_next = prod[DEN_W-1:0];
    end

    assign p2_rdy = !p2_vld_reg || dv_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else if (p2_rdy)
        begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_rdy && p1_vld_reg)
        begin
            p2_kind_reg <= kind_next;
            p2_bad_reg  <= p1_bad_reg;
            p2_num_reg  <= num_next;
            p2_mask_reg <= mask_next;
            p2_mu_reg   <= mu_next;
            p2_fr_reg   <= fr_next;
        end
    end

    // Divider stages; the mutation products ride along the first two.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  quo_in;
        logic              vld_in;
        logic [KIND_W-1:0] kind_in;
        logic              bad_in;
        logic              rdy_after;

        if (g == 0)
        begin : g_head
            assign rem_in  = p2_num_reg;
            assign quo_in  = '0;
            assign vld_in  = p2_vld_reg;
            assign kind_in = p2_kind_reg;
            assign bad_in  = p2_bad_reg;

            always_ff @(posedge clk)
            begin
                if (dv_rdy[g] && vld_in)
                begin
                    d0_mask_reg <= p2_mask_reg;
                    for (int j = 0; j < NUM_LANES; j++)
                    begin
                        d0_prod_reg[j] <= PROD_W'(p2_mu_reg[j]) * PROD_W'(p2_fr_reg[j]);
                    end
                end
            end
        end
        else
        begin : g_body
            assign rem_in  = dv_rem_reg[g-1];
            assign quo_in  = dv_quo_reg[g-1];
            assign vld_in  = dv_vld_reg[g-1];
            assign kind_in = dv_kind_reg[g-1];
            assign bad_in  = dv_bad_reg[g-1];

            if (g == 1)
            begin : g_sum
                always_ff @(posedge clk)
                begin
                    logic [MVAL_W-1:0] acc;
                    acc = '0;
                    for (int j = 0; j < NUM_LANES; j++)
                    begin
                        if (d0_mask_reg[j])
                        begin
                            acc = acc + MVAL_W'(d0_prod_reg[j][PROD_W-1:MUT_SHIFT]);
                        end
                    end
                    if (dv_rdy[g] && vld_in)
                    begin
                        mval_reg[g] <= acc;
                    end
                end
            end
            else
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (dv_rdy[g] && vld_in)
                    begin
                        mval_reg[g] <= mval_reg[g-1];
                    end
                end
            end
        end

        if (g == LAST)
        begin : g_tail
            assign rdy_after = out_rdy;
        end
        else
        begin : g_link
            assign rdy_after = dv_rdy[g+1];
        end

        assign dv_rdy[g] = !dv_vld_reg[g] || rdy_after;

        asre_div_step #(
            .DEN_W (DEN_W)
        ) u_div_step (
            .rem_in  (rem_in),
            .quo_in  (quo_in),
            .den     (den),
            .rem_out (dv_rem_next[g]),
            .quo_out (dv_quo_next[g])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[g] <= 1'b0;
            end
            else if (dv_rdy[g])
            begin
                dv_vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (dv_rdy[g] && vld_in)
            begin
                dv_rem_reg[g]  <= dv_rem_next[g];
                dv_quo_reg[g]  <= dv_quo_next[g];
                dv_kind_reg[g] <= kind_in;
                dv_bad_reg[g]  <= bad_in;
            end
        end
    end

    // Final selection and sign, then the output register.
    always_comb
    begin
        logic [QUO_W:0] q2;
        q2 = {dv_quo_reg[LAST], 1'b0};
        case (dv_kind_reg[LAST])
            K_DRIFT:  rate_next = RATE_W'(dv_quo_reg[LAST]);
            K_MUT:    rate_next = RATE_W'(mval_reg[LAST]);
            K_NDRIFT: rate_next = {RATE_W{1'b0}} - RATE_W'(q2);
            K_NMUT:   rate_next = {RATE_W{1'b0}} - RATE_W'(mval_reg[LAST]);
            default:  rate_next = '0;
        endcase
        if (dv_bad_reg[LAST])
        begin
            rate_next = '0;
        end
    end

    assign out_rdy = !out_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_vld_reg <= dv_vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && dv_vld_reg[LAST])
        begin
            out_rate_reg <= rate_next;
            out_bad_reg  <= dv_bad_reg[LAST];
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.rate      = $signed(out_rate_reg);
    assign result.bad_state = out_bad_reg;

    // A flagged index always comes out with a zero rate.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.bad_state |-> result.rate == '0)
        else $error("bad_state beat carries a nonzero rate");

    // Query stalls only while decode, classification and output stages are all full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !query.ready |-> p1_vld_reg && p2_vld_reg && out_vld_reg && !result.ready)
        else $error("query stalled while the pipeline has an empty slot");

    // A single mutation entry selects exactly one product lane.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[0] && (dv_kind_reg[0] == K_MUT) |-> $onehot(d0_mask_reg))
        else $error("mutation entry without a single lane");

    // A fixed-state diagonal sums all three lanes.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[0] && (dv_kind_reg[0] == K_NMUT) |-> d0_mask_reg == {NUM_LANES{1'b1}})
        else $error("fixed diagonal does not sum every lane");

endmodule
